// File: hdl/odh_pkg.sv
// shared types, constants and tables for the ordered dither halftone packer
// the dither threshold rom and the contrast and brightness lookup tables live here
// no dependencies
package odh_pkg;

  localparam int LANES = 8;
  localparam int PIX_W = 8;
  localparam int PHASE_W = 4;
  localparam int LW_W = 15;
  localparam int CFG_W = 15;
  localparam int IDX_W = 2;
  localparam int FACTOR_W = 18;
  localparam int BOFF_W = 25;
  localparam int PROD_W = 29;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int DEF_TILE_SIZE = 16;
  localparam int DEF_MAX_LINE_PIXELS = 16384;

  localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_CONTRAST = 2'd1;
  localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 18'd65536;
  localparam logic signed [PROD_W-1:0] MID_GREY_Q16 = 29'sd8388608;
  localparam logic signed [PROD_W-1:0] HALF_Q16 = 29'sd32768;

  typedef struct packed {
    logic [LANES-1:0] mask;
    logic [PHASE_W-1:0] row;
    logic [PHASE_W-1:0] colbase;
    logic last;
  } item_ctrl_t;

  typedef struct packed {
    logic [LANES-1:0][PIX_W-1:0] pixels;
    item_ctrl_t ctrl;
  } mid_entry_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic signed [BOFF_W-1:0] boff;
  } xfer_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] halftone;
    logic last;
  } out_entry_t;

  typedef logic [FACTOR_W-1:0] factor_lut_t [256];
  typedef logic signed [BOFF_W-1:0] bright_lut_t [256];

  // 1 + 0.0075c + 0.000025c^2 in q2.16, rounded half up
  function automatic factor_lut_t build_factor_lut();
    factor_lut_t t;
    longint c;
    longint num;
    for (int k = 0; k < 256; k++) begin
      c = (k >= 128) ? longint'(k) - 256 : longint'(k);
      num = (40000 + 300 * c + c * c) * 65536 + 20000;
      t[k] = FACTOR_W'(num / 40000);
    end
    return t;
  endfunction

  // 1.275b in q16, rounded half away from zero
  function automatic bright_lut_t build_bright_lut();
    bright_lut_t t;
    longint b;
    longint mag;
    for (int k = 0; k < 256; k++) begin
      b = (k >= 128) ? longint'(k) - 256 : longint'(k);
      if (b >= 0) begin
        mag = (b * 417792 + 2) / 5;
        t[k] = BOFF_W'(mag);
      end else begin
        mag = ((-b) * 417792 + 2) / 5;
        t[k] = BOFF_W'(-mag);
      end
    end
    return t;
  endfunction

  localparam factor_lut_t FACTOR_LUT = build_factor_lut();
  localparam bright_lut_t BRIGHT_LUT = build_bright_lut();

  localparam logic [7:0] DITHER_ROM [256] = '{
    8'h91,8'hB9,8'hB1,8'h89,8'h6B,8'h43,8'h4B,8'h73,8'h93,8'hBB,8'hB3,8'h8B,8'h69,8'h41,8'h49,8'h71,
    8'hC1,8'hF1,8'hE9,8'hA1,8'h3B,8'h0B,8'h13,8'h5B,8'hC3,8'hF3,8'hEB,8'hA3,8'h39,8'h09,8'h11,8'h59,
    8'hC9,8'hF9,8'hE1,8'hA9,8'h33,8'h03,8'h1B,8'h53,8'hCB,8'hFB,8'hE3,8'hAB,8'h31,8'h01,8'h19,8'h51,
    8'h99,8'hD9,8'hD1,8'h81,8'h63,8'h23,8'h2B,8'h7B,8'h9B,8'hDB,8'hD3,8'h83,8'h61,8'h21,8'h29,8'h79,
    8'h6C,8'h44,8'h4C,8'h74,8'h94,8'hBC,8'hB4,8'h8C,8'h6E,8'h46,8'h4E,8'h76,8'h96,8'hBE,8'hB6,8'h8E,
    8'h3C,8'h0C,8'h14,8'h5C,8'hC4,8'hF4,8'hEC,8'hA4,8'h3E,8'h0E,8'h16,8'h5E,8'hC6,8'hF6,8'hEE,8'hA6,
    8'h34,8'h04,8'h1C,8'h54,8'hCC,8'hFC,8'hE4,8'hAC,8'h36,8'h06,8'h1E,8'h56,8'hCE,8'hFE,8'hE6,8'hAE,
    8'h64,8'h24,8'h2C,8'h7C,8'h9C,8'hDC,8'hD4,8'h84,8'h66,8'h26,8'h2E,8'h7E,8'h9E,8'hDE,8'hD6,8'h86,
    8'h92,8'hBA,8'hB2,8'h8A,8'h68,8'h40,8'h48,8'h70,8'h90,8'hB8,8'hB0,8'h88,8'h6A,8'h42,8'h4A,8'h72,
    8'hC2,8'hF2,8'hEA,8'hA2,8'h38,8'h08,8'h10,8'h58,8'hC0,8'hF0,8'hE8,8'hA0,8'h3A,8'h0A,8'h12,8'h5A,
    8'hCA,8'hFA,8'hE2,8'hAA,8'h30,8'h00,8'h18,8'h50,8'hC8,8'hF8,8'hE0,8'hA8,8'h32,8'h02,8'h1A,8'h52,
    8'h9A,8'hDA,8'hD2,8'h82,8'h60,8'h20,8'h28,8'h78,8'h98,8'hD8,8'hD0,8'h80,8'h62,8'h22,8'h2A,8'h7A,
    8'h6F,8'h47,8'h4F,8'h77,8'h97,8'hBF,8'hB7,8'h8F,8'h6D,8'h45,8'h4D,8'h75,8'h95,8'hBD,8'hB5,8'h8D,
    8'h3F,8'h0F,8'h17,8'h5F,8'hC7,8'hF7,8'hEF,8'hA7,8'h3D,8'h0D,8'h15,8'h5D,8'hC5,8'hF5,8'hED,8'hA5,
    8'h37,8'h07,8'h1F,8'h57,8'hCF,8'hFE,8'hE7,8'hAF,8'h35,8'h05,8'h1D,8'h55,8'hCD,8'hFD,8'hE5,8'hAD,
    8'h67,8'h27,8'h2F,8'h7F,8'h9F,8'hDF,8'hD7,8'h87,8'h65,8'h25,8'h2D,8'h7D,8'h9D,8'hDD,8'hD5,8'h85
  };

endpackage

// File: hdl/odh_fifo.sv
// small first-in first-out queue built from flops, used between front and back
// and as the result queue
// depends on nothing
module odh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign level = count;
  assign dout = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/odh_front.sv
// front end: configuration registers, row position tracking and classification
// of each accepted item into lane mask, dither row and column base
// depends on odh_pkg
module odh_front
  import odh_pkg::*;
#(
  parameter int TILE_SIZE = DEF_TILE_SIZE,
  parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_index,
  input  logic [CFG_W-1:0]             wr_data,
  input  logic                         item_push,
  input  logic [LANES-1:0][PIX_W-1:0]  item_pixels,
  input  logic                         item_frame_start,
  input  logic                         mid_full,
  output logic                         mid_push,
  output mid_entry_t                   mid_data,
  output xfer_cfg_t                    xcfg
);

  localparam int NGROUPS = (MAX_LINE_PIXELS + LANES - 1) / LANES;
  localparam int GW = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int WE_W = $clog2(MAX_LINE_PIXELS + 1);
  localparam int WC_W = (WE_W > LW_W) ? WE_W : LW_W;
  localparam logic [WC_W-1:0] MAX_W = WC_W'(MAX_LINE_PIXELS);

  logic [GW-1:0] last_group;
  logic [2:0] tail;
  logic [FACTOR_W-1:0] factor;
  logic signed [BOFF_W-1:0] boff;

  logic [GW-1:0] group;
  logic [GW-1:0] group_next;
  logic [PHASE_W-1:0] row_phase;
  logic [PHASE_W-1:0] row_phase_next;
  logic [PHASE_W-1:0] colbase;
  logic [PHASE_W-1:0] colbase_next;

  logic [WC_W-1:0] lw_ext;
  logic [WC_W-1:0] weff;
  logic [WC_W-1:0] wm1;

  logic [GW-1:0] cur_group;
  logic [PHASE_W-1:0] cur_row;
  logic [PHASE_W-1:0] cur_cb;
  logic last;
  logic accept;
  logic [PHASE_W:0] cb_plus;
  logic [PHASE_W:0] cb_wrap;

  // effective width: zero counts as one, large values saturate
  always_comb begin
    lw_ext = WC_W'(wr_data[LW_W-1:0]);
    if (lw_ext == '0) begin
      weff = WC_W'(1);
    end else if (lw_ext > MAX_W) begin
      weff = MAX_W;
    end else begin
      weff = lw_ext;
    end
    wm1 = weff - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_group <= '0;
      tail <= '0;
      factor <= FACTOR_ONE;
      boff <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LINE_WIDTH: begin
          last_group <= GW'(wm1 >> 3);
          tail <= weff[2:0];
        end
        REG_CONTRAST: begin
          factor <= FACTOR_LUT[wr_data[7:0]];
        end
        REG_BRIGHTNESS: begin
          boff <= BRIGHT_LUT[wr_data[7:0]];
        end
        default: begin
        end
      endcase
    end
  end

  assign xcfg.factor = factor;
  assign xcfg.boff = boff;

  assign accept = item_push && !mid_full;
  assign mid_push = accept;

  always_comb begin
    cur_group = item_frame_start ? '0 : group;
    cur_row = item_frame_start ? '0 : row_phase;
    cur_cb = item_frame_start ? '0 : colbase;
    last = (cur_group >= last_group);

    cb_plus = {1'b0, cur_cb} + (PHASE_W + 1)'(LANES);
    cb_wrap = (cb_plus >= (PHASE_W + 1)'(TILE_SIZE)) ?
              cb_plus - (PHASE_W + 1)'(TILE_SIZE) : cb_plus;

    if (last) begin
      group_next = '0;
      colbase_next = '0;
      row_phase_next = (cur_row == PHASE_W'(TILE_SIZE - 1)) ? '0 : cur_row + 1'b1;
    end else begin
      group_next = cur_group + 1'b1;
      colbase_next = cb_wrap[PHASE_W-1:0];
      row_phase_next = cur_row;
    end

    mid_data.pixels = item_pixels;
    mid_data.ctrl.row = cur_row;
    mid_data.ctrl.colbase = cur_cb;
    mid_data.ctrl.last = last;
    if (last && (tail != 3'd0)) begin
      mid_data.ctrl.mask = {LANES{1'b1}} << (4'(LANES) - {1'b0, tail});
    end else begin
      mid_data.ctrl.mask = {LANES{1'b1}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group <= '0;
      row_phase <= '0;
      colbase <= '0;
    end else if (accept) begin
      group <= group_next;
      row_phase <= row_phase_next;
      colbase <= colbase_next;
    end
  end

endmodule

// File: hdl/odh_back.sv
// back end: two stage transfer and threshold pipeline over eight pixel lanes
// issues from the front queue only when the result queue has room
// depends on odh_pkg
module odh_back
  import odh_pkg::*;
#(
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mid_empty,
  input  mid_entry_t           mid_data,
  output logic                 mid_pop,
  input  xfer_cfg_t            xcfg,
  input  logic [OUT_CNT_W-1:0] out_level,
  output logic                 out_push,
  output out_entry_t           out_data,
  output logic [1:0]           busy
);

  logic issue;
  logic [OUT_CNT_W:0] room_sum;

  logic s1_valid;
  logic signed [PROD_W-1:0] s1_prod [LANES];
  logic [PIX_W-1:0] s1_th [LANES];
  logic [LANES-1:0] s1_mask;
  logic s1_last;

  logic s2_valid;
  out_entry_t s2_data;

  logic signed [PROD_W-1:0] prod_c [LANES];
  logic [PIX_W-1:0] th_c [LANES];
  logic [LANES-1:0] bit_c;

  assign busy = {1'b0, s1_valid} + {1'b0, s2_valid};
  assign room_sum = {1'b0, out_level} + (OUT_CNT_W + 1)'(busy);
  assign issue = !mid_empty && (room_sum < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign mid_pop = issue;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [PIX_W+1:0] diff;
    logic [PHASE_W:0] col_sum;
    logic [PHASE_W:0] col;
    logic signed [PROD_W-1:0] x;
    logic signed [PROD_W-1:0] xr;
    logic [PIX_W-1:0] v;
    logic [PIX_W:0] tsum;

    // stage one: centered pixel times contrast factor, threshold lookup
    assign diff = $signed({2'b00, mid_data.pixels[i]}) - (PIX_W + 2)'(128);
    assign prod_c[i] = PROD_W'(diff * $signed({1'b0, xcfg.factor}));
    assign col_sum = {1'b0, mid_data.ctrl.colbase} + (PHASE_W + 1)'(i);
    assign col = (col_sum >= (PHASE_W + 1)'(TILE_SIZE)) ?
                 col_sum - (PHASE_W + 1)'(TILE_SIZE) : col_sum;
    assign th_c[i] = ~DITHER_ROM[{mid_data.ctrl.row, col[PHASE_W-1:0]}];

    // stage two: offset, round half up, clamp, threshold
    assign x = s1_prod[i] + MID_GREY_Q16 + PROD_W'(xcfg.boff);
    assign xr = x + HALF_Q16;
    always_comb begin
      if (x[PROD_W-1]) begin
        v = '0;
      end else if (|xr[PROD_W-2:PIX_W+16]) begin
        v = '1;
      end else begin
        v = xr[PIX_W+15:16];
      end
    end
    assign tsum = {1'b0, v} + {1'b0, s1_th[i]};
    assign bit_c[LANES-1-i] = tsum[PIX_W] & s1_mask[LANES-1-i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      s1_prod[i] <= prod_c[i];
      s1_th[i] <= th_c[i];
    end
    s1_mask <= mid_data.ctrl.mask;
    s1_last <= mid_data.ctrl.last;
    s2_data.halftone <= bit_c;
    s2_data.last <= s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  assign out_push = s2_valid;
  assign out_data = s2_data;

endmodule

// File: hdl/ordered_dither_halftone_packer.sv
// top level of the ordered dither halftone packer
// depends on odh_pkg, odh_front, odh_fifo and odh_back
//
// input channel: pixel_0..pixel_7 and frame_start are taken at a rising edge with
// push high and full low. frame_start restarts row and dither position.
// result channel: packed_byte and row_end show the oldest result while empty is
// low; it is taken at a rising edge with pop high and empty low. pixel_0 lands in
// bit 7, pixels past the row end read as zero.
// configuration: wr_en, wr_index, wr_data; index 0 line width, 1 contrast,
// 2 brightness, others ignored. write only while the block is idle.
// an item passes the front queue, both pipeline stages and the result queue.
// throughput: one item per cycle while pop keeps up, set by the two stage transfer
// pipeline (one multiply per lane, in the first stage) fed from a four entry front
// queue. reset: clears both queues and the row position; line width 8, contrast 0,
// brightness 0.
// when pop stays low, the four entry result queue fills, the pipeline stops
// issuing, the front queue fills, and full rises.
module ordered_dither_halftone_packer
  import odh_pkg::*;
#(
  parameter int TILE_SIZE = DEF_TILE_SIZE,
  parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_0,
  input  logic [PIX_W-1:0] pixel_1,
  input  logic [PIX_W-1:0] pixel_2,
  input  logic [PIX_W-1:0] pixel_3,
  input  logic [PIX_W-1:0] pixel_4,
  input  logic [PIX_W-1:0] pixel_5,
  input  logic [PIX_W-1:0] pixel_6,
  input  logic [PIX_W-1:0] pixel_7,
  input  logic             frame_start,
  output logic             empty,
  input  logic             pop,
  output logic [PIX_W-1:0] packed_byte,
  output logic             row_end,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  logic [LANES-1:0][PIX_W-1:0] pixels;
  logic mid_push;
  mid_entry_t mid_din;
  mid_entry_t mid_dout;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_level;
  xfer_cfg_t xcfg;
  logic out_push;
  out_entry_t out_din;
  out_entry_t out_dout;
  logic out_full;
  logic [OUT_CNT_W-1:0] out_level;
  logic [1:0] busy;

  assign pixels[0] = pixel_0;
  assign pixels[1] = pixel_1;
  assign pixels[2] = pixel_2;
  assign pixels[3] = pixel_3;
  assign pixels[4] = pixel_4;
  assign pixels[5] = pixel_5;
  assign pixels[6] = pixel_6;
  assign pixels[7] = pixel_7;

  assign full = mid_full;

  odh_front #(
    .TILE_SIZE(TILE_SIZE),
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .item_push(push),
    .item_pixels(pixels),
    .item_frame_start(frame_start),
    .mid_full(mid_full),
    .mid_push(mid_push),
    .mid_data(mid_din),
    .xcfg(xcfg)
  );

  odh_fifo #(
    .WIDTH($bits(mid_entry_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk(clk),
    .rst(rst),
    .push(mid_push),
    .din(mid_din),
    .full(mid_full),
    .pop(mid_pop),
    .dout(mid_dout),
    .empty(mid_empty),
    .level(mid_level)
  );

  odh_back #(
    .TILE_SIZE(TILE_SIZE)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .mid_empty(mid_empty),
    .mid_data(mid_dout),
    .mid_pop(mid_pop),
    .xcfg(xcfg),
    .out_level(out_level),
    .out_push(out_push),
    .out_data(out_din),
    .busy(busy)
  );

  odh_fifo #(
    .WIDTH($bits(out_entry_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk(clk),
    .rst(rst),
    .push(out_push),
    .din(out_din),
    .full(out_full),
    .pop(pop),
    .dout(out_dout),
    .empty(empty),
    .level(out_level)
  );

  assign packed_byte = out_dout.halftone;
  assign row_end = out_dout.last;

  // results in flight never exceed the room left in the result queue
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result queue written while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, out_level} + (OUT_CNT_W + 1)'(busy)) <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("in-flight items exceed result queue space");

  a_mid_level: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty && (mid_level != '0))
    else $error("front queue popped while empty");

  // a frame start item always begins at the top left of the dither tile
  a_frame_origin: assert property (@(posedge clk) disable iff (rst)
    (mid_push && frame_start) |->
      (mid_din.ctrl.row == '0) && (mid_din.ctrl.colbase == '0))
    else $error("frame start item not at tile origin");

endmodule

// File: tb/odh_checker.sv
`timescale 1ns / 1ps
// halftone byte checker for the ordered dither halftone packer: keeps its own copy of the
// registers and row position, predicts each packed byte and compares it with the result side
// depends on odh_pkg
module odh_checker
  import odh_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic [LANES-1:0][PIX_W-1:0]  pixels,
  input  logic                         frame_start,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [PIX_W-1:0]             packed_byte,
  input  logic                         row_end,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_index,
  input  logic [CFG_W-1:0]             wr_data,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output int                           row_ends
);

  localparam int TILE = DEF_TILE_SIZE;
  localparam int MAX_LINE = DEF_MAX_LINE_PIXELS;

  localparam logic [7:0] DITHER_CELLS [256] = '{
    8'h91,8'hB9,8'hB1,8'h89,8'h6B,8'h43,8'h4B,8'h73,8'h93,8'hBB,8'hB3,8'h8B,8'h69,8'h41,8'h49,8'h71,
    8'hC1,8'hF1,8'hE9,8'hA1,8'h3B,8'h0B,8'h13,8'h5B,8'hC3,8'hF3,8'hEB,8'hA3,8'h39,8'h09,8'h11,8'h59,
    8'hC9,8'hF9,8'hE1,8'hA9,8'h33,8'h03,8'h1B,8'h53,8'hCB,8'hFB,8'hE3,8'hAB,8'h31,8'h01,8'h19,8'h51,
    8'h99,8'hD9,8'hD1,8'h81,8'h63,8'h23,8'h2B,8'h7B,8'h9B,8'hDB,8'hD3,8'h83,8'h61,8'h21,8'h29,8'h79,
    8'h6C,8'h44,8'h4C,8'h74,8'h94,8'hBC,8'hB4,8'h8C,8'h6E,8'h46,8'h4E,8'h76,8'h96,8'hBE,8'hB6,8'h8E,
    8'h3C,8'h0C,8'h14,8'h5C,8'hC4,8'hF4,8'hEC,8'hA4,8'h3E,8'h0E,8'h16,8'h5E,8'hC6,8'hF6,8'hEE,8'hA6,
    8'h34,8'h04,8'h1C,8'h54,8'hCC,8'hFC,8'hE4,8'hAC,8'h36,8'h06,8'h1E,8'h56,8'hCE,8'hFE,8'hE6,8'hAE,
    8'h64,8'h24,8'h2C,8'h7C,8'h9C,8'hDC,8'hD4,8'h84,8'h66,8'h26,8'h2E,8'h7E,8'h9E,8'hDE,8'hD6,8'h86,
    8'h92,8'hBA,8'hB2,8'h8A,8'h68,8'h40,8'h48,8'h70,8'h90,8'hB8,8'hB0,8'h88,8'h6A,8'h42,8'h4A,8'h72,
    8'hC2,8'hF2,8'hEA,8'hA2,8'h38,8'h08,8'h10,8'h58,8'hC0,8'hF0,8'hE8,8'hA0,8'h3A,8'h0A,8'h12,8'h5A,
    8'hCA,8'hFA,8'hE2,8'hAA,8'h30,8'h00,8'h18,8'h50,8'hC8,8'hF8,8'hE0,8'hA8,8'h32,8'h02,8'h1A,8'h52,
    8'h9A,8'hDA,8'hD2,8'h82,8'h60,8'h20,8'h28,8'h78,8'h98,8'hD8,8'hD0,8'h80,8'h62,8'h22,8'h2A,8'h7A,
    8'h6F,8'h47,8'h4F,8'h77,8'h97,8'hBF,8'hB7,8'h8F,8'h6D,8'h45,8'h4D,8'h75,8'h95,8'hBD,8'hB5,8'h8D,
    8'h3F,8'h0F,8'h17,8'h5F,8'hC7,8'hF7,8'hEF,8'hA7,8'h3D,8'h0D,8'h15,8'h5D,8'hC5,8'hF5,8'hED,8'hA5,
    8'h37,8'h07,8'h1F,8'h57,8'hCF,8'hFE,8'hE7,8'hAF,8'h35,8'h05,8'h1D,8'h55,8'hCD,8'hFD,8'hE5,8'hAD,
    8'h67,8'h27,8'h2F,8'h7F,8'h9F,8'hDF,8'hD7,8'h87,8'h65,8'h25,8'h2D,8'h7D,8'h9D,8'hDD,8'hD5,8'h85
  };

  typedef struct packed {
    logic [PIX_W-1:0] bits;
    logic last;
  } halftone_t;

  halftone_t halftone_q [$];

  logic [LW_W-1:0] width_reg;
  logic signed [7:0] contrast_reg;
  logic signed [7:0] brightness_reg;
  logic [FACTOR_W-1:0] gain_reg;
  int unsigned group_idx;
  int unsigned row_idx;

  // q2.16 gain 1 + 0.0075c + 0.000025c^2, rounded half up
  function automatic logic [FACTOR_W-1:0] contrast_gain(input logic signed [7:0] c);
    longint cc;
    longint num;
    cc = c;
    num = (40000 + 300 * cc + cc * cc) * 65536;
    return FACTOR_W'((num + 20000) / 40000);
  endfunction

  // q16 offset of 1.275b, rounded half away from zero
  function automatic longint bright_q16(input logic signed [7:0] b);
    longint bb;
    bb = b;
    if (bb >= 0) return (bb * 417792 + 2) / 5;
    return -(((-bb) * 417792 + 2) / 5);
  endfunction

  function automatic int unsigned adjust_grey(input logic [PIX_W-1:0] v,
                                              input logic [FACTOR_W-1:0] gain,
                                              input longint boff);
    longint vv;
    longint gg;
    longint x;
    longint r;
    vv = v;
    gg = gain;
    x = (vv - 128) * gg + (longint'(128) <<< 16) + boff;
    if (x < 0) return 0;
    r = (x + 32768) >>> 16;
    if (r > 255) return 255;
    return int'(r);
  endfunction

  task automatic predict_halftone(input logic [LANES-1:0][PIX_W-1:0] px, input logic fs,
                                  output halftone_t res);
    int unsigned w;
    int unsigned groups;
    int unsigned count;
    int unsigned colbase;
    int unsigned col;
    int unsigned grey;
    int unsigned thr;
    longint boff;
    logic last;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_LINE) w = MAX_LINE;
    if (fs) begin
      group_idx = 0;
      row_idx = 0;
    end
    groups = (w + 7) / 8;
    last = (group_idx >= groups - 1);
    count = (last && (w % 8) != 0) ? w % 8 : 8;
    colbase = (group_idx * 8) % TILE;
    boff = bright_q16(brightness_reg);
    res.bits = '0;
    for (int i = 0; i < count; i++) begin
      col = (colbase + i) % TILE;
      thr = 255 - DITHER_CELLS[(row_idx % TILE) * 16 + col];
      grey = adjust_grey(px[i], gain_reg, boff);
      if (((grey + thr) & 256) != 0) res.bits[7 - i] = 1'b1;
    end
    res.last = last;
    if (last) begin
      group_idx = 0;
      row_idx = (row_idx + 1) % TILE;
    end else begin
      group_idx++;
    end
  endtask

  always @(posedge clk) begin : watch
    halftone_t want;
    if (rst) begin
      width_reg = LW_W'(8);
      contrast_reg = '0;
      brightness_reg = '0;
      gain_reg = contrast_gain(8'sd0);
      group_idx = 0;
      row_idx = 0;
      halftone_q.delete();
      fail_count = 0;
      checked = 0;
      row_ends = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_LINE_WIDTH: width_reg = wr_data[LW_W-1:0];
          REG_CONTRAST: begin
            contrast_reg = wr_data[7:0];
            gain_reg = contrast_gain(contrast_reg);
          end
          REG_BRIGHTNESS: brightness_reg = wr_data[7:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        predict_halftone(pixels, frame_start, want);
        halftone_q.push_back(want);
      end
      if (pop && !empty) begin
        if (halftone_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: byte %02h row_end %0b arrived with nothing pending",
                     $realtime, packed_byte, row_end);
          fail_count++;
        end else begin
          want = halftone_q.pop_front();
          checked++;
          if (row_end) row_ends++;
          if (packed_byte !== want.bits || row_end !== want.last) begin
            if (fail_count < 10)
              $display("%0t: byte %0d expected %02h row_end %0b, got %02h row_end %0b",
                       $realtime, checked, want.bits, want.last, packed_byte, row_end);
            fail_count++;
          end
        end
      end
    end
    pending <= halftone_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// stimulus and verdict for the ordered dither halftone packer: directed register corners,
// then random phases of pixel groups under random push and pop idling
// depends on odh_pkg, ordered_dither_halftone_packer and odh_checker
module tb_top;
  import odh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_GROUPS = 1100;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic [PIX_W-1:0] pixel_0;
  logic [PIX_W-1:0] pixel_1;
  logic [PIX_W-1:0] pixel_2;
  logic [PIX_W-1:0] pixel_3;
  logic [PIX_W-1:0] pixel_4;
  logic [PIX_W-1:0] pixel_5;
  logic [PIX_W-1:0] pixel_6;
  logic [PIX_W-1:0] pixel_7;
  logic frame_start;
  logic empty;
  logic pop;
  logic [PIX_W-1:0] packed_byte;
  logic row_end;
  logic wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  logic push_burst;
  logic pop_burst;
  int fail_count;
  int pending;
  int checked;
  int row_ends;
  int groups_sent = 0;
  int phases = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ordered_dither_halftone_packer dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .pixel_0(pixel_0), .pixel_1(pixel_1), .pixel_2(pixel_2), .pixel_3(pixel_3),
    .pixel_4(pixel_4), .pixel_5(pixel_5), .pixel_6(pixel_6), .pixel_7(pixel_7),
    .frame_start(frame_start),
    .empty(empty), .pop(pop), .packed_byte(packed_byte), .row_end(row_end),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  odh_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pixels({pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0}),
    .frame_start(frame_start), .empty(empty), .pop(pop),
    .packed_byte(packed_byte), .row_end(row_end),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending), .checked(checked), .row_ends(row_ends)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d bytes pending", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(120 + $urandom_range(0, 16));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [LANES-1:0][PIX_W-1:0] rand_group();
    logic [LANES-1:0][PIX_W-1:0] g;
    for (int i = 0; i < LANES; i++) g[i] = rand_pixel();
    return g;
  endfunction

  // contrast and brightness share the same corners
  function automatic logic [7:0] pick_signed8();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h9C;
      3: return 8'h64;
      4: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly short rows so rows close and the row phase wraps
  function automatic logic [LW_W-1:0] pick_width();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return LW_W'(DEF_MAX_LINE_PIXELS);
      2: return '1;
      3: return LW_W'($urandom);
      4, 5: return LW_W'($urandom_range(41, 300));
      default: return LW_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic send_group(input logic [LANES-1:0][PIX_W-1:0] g, input logic fs);
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pixel_0 <= g[0];
    pixel_1 <= g[1];
    pixel_2 <= g[2];
    pixel_3 <= g[3];
    pixel_4 <= g[4];
    pixel_5 <= g[5];
    pixel_6 <= g[6];
    pixel_7 <= g[7];
    frame_start <= fs;
    @(posedge clk);
    while (full) @(posedge clk);
    groups_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // leaves wr_en high so back to back writes never lower it in between
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [LW_W-1:0] w, input logic [7:0] c,
                           input logic [7:0] b);
    write_reg(REG_LINE_WIDTH, CFG_W'(w));
    write_reg(REG_CONTRAST, {7'($urandom), c});
    write_reg(REG_BRIGHTNESS, {7'($urandom), b});
    wr_en <= 1'b0;
    phases++;
  endtask

  initial begin
    int gap;
    pop = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = pop_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    push = 1'b0;
    pixel_0 = '0;
    pixel_1 = '0;
    pixel_2 = '0;
    pixel_3 = '0;
    pixel_4 = '0;
    pixel_5 = '0;
    pixel_6 = '0;
    pixel_7 = '0;
    frame_start = 1'b0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    push_burst = 1'b1;
    pop_burst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers as they come out of reset
    send_group({8{8'h00}}, 1'b1);
    send_group({8{8'hFF}}, 1'b0);
    send_group({8'hFF, 8'hDB, 8'hB6, 8'h92, 8'h6D, 8'h49, 8'h24, 8'h00}, 1'b0);
    send_group({4{8'h55, 8'hAA}}, 1'b0);

    // nine pixel rows: one full group, then a one pixel group
    wait_idle();
    configure(LW_W'(9), 8'h7F, 8'h80);
    push_burst = 1'b0;
    pop_burst = 1'b0;
    send_group({8{8'hFF}}, 1'b1);
    send_group({8{8'hFF}}, 1'b0);
    send_group(rand_group(), 1'b0);
    send_group(rand_group(), 1'b1);

    // zero width acts as one pixel
    wait_idle();
    configure('0, 8'h80, 8'h7F);
    repeat (3) send_group(rand_group(), 1'b0);

    // oversized width, then a narrower width mid row ends the row at once
    wait_idle();
    write_reg(REG_UNUSED, '1);
    configure('1, 8'h64, 8'h9C);
    push_burst = 1'b1;
    send_group({8{8'h00}}, 1'b1);
    send_group(rand_group(), 1'b0);
    wait_idle();
    configure(LW_W'(16), 8'h9C, 8'h64);
    repeat (3) send_group(rand_group(), 1'b0);

    while (groups_sent < 16 + RANDOM_GROUPS) begin
      wait_idle();
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
      configure(pick_width(), pick_signed8(), pick_signed8());
      push_burst = ($urandom_range(0, 3) == 0);
      pop_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 60);
      for (int k = 0; k < n; k++)
        send_group(rand_group(),
                   (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 23) == 0));
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d pixel groups across %0d register settings", groups_sent, phases);
    $display("checked %0d packed bytes, %0d of them closing a row", checked, row_ends);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
